/* hw/rtl/hcbd_pkg.sv */
package hcbd_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 48;

   localparam logic [CsrIndexWidth-1:0] CSR_MAX_CHUNK = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_BODY  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_LINE  = 2'd2;

   localparam logic [31:0] MAX_CHUNK_RESET = 32'd16777216;
   localparam logic [47:0] MAX_BODY_RESET  = 48'd67108864;
   localparam logic [12:0] MAX_LINE_RESET  = 13'd4096;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_EMPTY_SIZE = 3'd0;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd1;
   localparam logic [2:0] ERR_LINE_LONG  = 3'd2;
   localparam logic [2:0] ERR_CHUNK_BIG  = 3'd3;
   localparam logic [2:0] ERR_BODY_BIG   = 3'd4;

   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SP   = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_body;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last_of_chunk;
      logic [2:0] error_code;
   } rsp_item_type;

endpackage

/* hw/rtl/http_chunked_body_decoder.sv */
// A result is registered and appears on rsp in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register frees up in the same
// cycle it is taken, so req_ready only drops while a result is stalled.
// Reset (synchronous, active high): parser returns to the size line with all
// counts cleared, limits return to their defaults, no result pending.
module http_chunked_body_decoder
   import hcbd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam logic [2:0] PH_SIZE  = 3'd0;
   localparam logic [2:0] PH_DATA  = 3'd1;
   localparam logic [2:0] PH_POST  = 3'd2;
   localparam logic [2:0] PH_TRAIL = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_ERR   = 3'd5;

   localparam int unsigned FL_EXT     = 0;
   localparam int unsigned FL_STARTED = 1;
   localparam int unsigned FL_BAD     = 2;

   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   logic [31:0] max_chunk_ff;
   logic [47:0] max_body_ff;
   logic [12:0] max_line_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [63:0] accum_ff, accum_in;
   logic [4:0]  digits_ff, digits_in;
   logic [2:0]  flags_ff, flags_in;
   logic        cr_ff, cr_in;
   logic [12:0] line_len_ff, line_len_in;
   logic [31:0] left_ff, left_in;
   logic [48:0] total_ff, total_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         emit;

   logic       accept;
   logic [7:0] b;
   logic [4:0] hex;
   logic [13:0] len_next;
   logic [31:0] left_dec;
   logic [48:0] total_sum;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign b         = req_item.in_byte;
   assign hex       = hex_decode(b);
   assign left_dec  = left_ff - 32'd1;

   always_comb begin
      phase_in    = req_item.new_body ? PH_SIZE : phase_ff;
      accum_in    = req_item.new_body ? 64'd0 : accum_ff;
      digits_in   = req_item.new_body ? 5'd0 : digits_ff;
      flags_in    = req_item.new_body ? 3'd0 : flags_ff;
      cr_in       = req_item.new_body ? 1'b0 : cr_ff;
      line_len_in = req_item.new_body ? 13'd0 : line_len_ff;
      left_in     = req_item.new_body ? 32'd0 : left_ff;
      total_in    = req_item.new_body ? 49'd0 : total_ff;
      len_next    = {1'b0, line_len_in} + 14'd1;
      total_sum   = total_in + {17'd0, accum_in[31:0]};
      emit        = 1'b0;
      rsp_in      = '0;

      case (phase_in)
         PH_DATA: begin
            left_in     = left_dec;
            emit        = 1'b1;
            rsp_in.kind = KIND_DATA;
            rsp_in.data = b;
            if (left_dec == 32'd0) begin
               rsp_in.last_of_chunk = 1'b1;
               phase_in    = PH_POST;
               accum_in    = 64'd0;
               digits_in   = 5'd0;
               flags_in    = 3'd0;
               cr_in       = 1'b0;
               line_len_in = 13'd0;
            end
         end
         PH_SIZE, PH_POST, PH_TRAIL: begin
            if (b == CH_LF) begin
               if (phase_in == PH_SIZE && !flags_in[FL_STARTED]) begin
                  phase_in          = PH_ERR;
                  emit              = 1'b1;
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.error_code = ERR_EMPTY_SIZE;
               end else if (phase_in == PH_SIZE &&
                            (flags_in[FL_BAD] || digits_in > 5'd16)) begin
                  phase_in          = PH_ERR;
                  emit              = 1'b1;
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.error_code = ERR_BAD_HEX;
               end else if (phase_in == PH_SIZE) begin
                  if (accum_in == 64'd0) begin
                     phase_in = PH_TRAIL;
                  end else if (accum_in > {32'd0, max_chunk_ff}) begin
                     phase_in          = PH_ERR;
                     emit              = 1'b1;
                     rsp_in.kind       = KIND_ERROR;
                     rsp_in.error_code = ERR_CHUNK_BIG;
                  end else if (total_sum > {1'b0, max_body_ff}) begin
                     phase_in          = PH_ERR;
                     emit              = 1'b1;
                     rsp_in.kind       = KIND_ERROR;
                     rsp_in.error_code = ERR_BODY_BIG;
                  end else begin
                     total_in = total_sum;
                     left_in  = accum_in[31:0];
                     phase_in = PH_DATA;
                  end
                  accum_in    = 64'd0;
                  digits_in   = 5'd0;
                  flags_in    = 3'd0;
                  cr_in       = 1'b0;
                  line_len_in = 13'd0;
               end else begin
                  if (phase_in == PH_POST) begin
                     phase_in = PH_SIZE;
                  end else if (line_len_in == 13'd0 || (line_len_in == 13'd1 && cr_in)) begin
                     phase_in    = PH_DONE;
                     emit        = 1'b1;
                     rsp_in.kind = KIND_DONE;
                  end
                  accum_in    = 64'd0;
                  digits_in   = 5'd0;
                  flags_in    = 3'd0;
                  cr_in       = 1'b0;
                  line_len_in = 13'd0;
               end
            end else if (len_next > {1'b0, max_line_ff}) begin
               phase_in          = PH_ERR;
               emit              = 1'b1;
               rsp_in.kind       = KIND_ERROR;
               rsp_in.error_code = ERR_LINE_LONG;
            end else begin
               line_len_in = len_next[12:0];
               if (phase_in == PH_SIZE && !flags_in[FL_EXT]) begin
                  if (cr_in) begin
                     flags_in[FL_STARTED] = 1'b1;
                     flags_in[FL_BAD]     = 1'b1;
                  end
                  if (b == CH_SEMI) begin
                     flags_in[FL_EXT] = 1'b1;
                  end else if (b == CH_CR) begin
                     // dropped if LF follows
                  end else if (b == CH_SP || b == CH_TAB) begin
                     if (flags_in[FL_STARTED]) begin
                        flags_in[FL_BAD] = 1'b1;
                     end
                  end else if (hex[4]) begin
                     flags_in[FL_STARTED] = 1'b1;
                     if (hex[3:0] != 4'd0 || digits_in != 5'd0) begin
                        if (digits_in < 5'd16) begin
                           accum_in  = {accum_in[59:0], hex[3:0]};
                           digits_in = digits_in + 5'd1;
                        end else begin
                           digits_in = 5'd17;
                        end
                     end
                  end else begin
                     flags_in[FL_STARTED] = 1'b1;
                     flags_in[FL_BAD]     = 1'b1;
                  end
               end
               cr_in = (b == CH_CR);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_ff <= MAX_CHUNK_RESET;
         max_body_ff  <= MAX_BODY_RESET;
         max_line_ff  <= MAX_LINE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_CHUNK: max_chunk_ff <= csr_data[31:0];
            CSR_MAX_BODY:  max_body_ff  <= csr_data[47:0];
            CSR_MAX_LINE:  max_line_ff  <= csr_data[12:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         accum_ff     <= 64'd0;
         digits_ff    <= 5'd0;
         flags_ff     <= 3'd0;
         cr_ff        <= 1'b0;
         line_len_ff  <= 13'd0;
         left_ff      <= 32'd0;
         total_ff     <= 49'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            accum_ff    <= accum_in;
            digits_ff   <= digits_in;
            flags_ff    <= flags_in;
            cr_ff       <= cr_in;
            line_len_ff <= line_len_in;
            left_ff     <= left_in;
            total_ff    <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hw/rtl/hcbd_checker.sv */
module hcbd_checker
   import hcbd_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input req_item_type             req_item,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsp_item_type             rsp_item,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [CsrIndexWidth-1:0] csr_index,
   input logic [CsrDataWidth-1:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp transfer changed while stalled");

   a_new_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

   a_non_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind != KIND_DATA |->
         rsp_item.data == 8'd0 && !rsp_item.last_of_chunk)
      else $error("data or last set on a non-data result");

   a_error_code_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind != KIND_ERROR |-> rsp_item.error_code == ERR_EMPTY_SIZE)
      else $error("error code set on a non-error result");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte taken while a result is stalled");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);
